// ----- sv/ssi_pkg.sv -----
// Shared control types for the segment intersection pipeline.
package ssi_pkg;

  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } ssi_ctl_t;

endpackage

// ----- sv/ssi_front.sv -----
// Front stages: edge vectors, cross-product terms and the three cross products.
module ssi_front #(
  parameter int W = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic signed [W-1:0]     a_start_x_i,
  input  logic signed [W-1:0]     a_start_y_i,
  input  logic signed [W-1:0]     a_end_x_i,
  input  logic signed [W-1:0]     a_end_y_i,
  input  logic signed [W-1:0]     b_start_x_i,
  input  logic signed [W-1:0]     b_start_y_i,
  input  logic signed [W-1:0]     b_end_x_i,
  input  logic signed [W-1:0]     b_end_y_i,
  output logic                    valid_o,
  output logic signed [W:0]       d0x_o,
  output logic signed [W:0]       d0y_o,
  output logic signed [W-1:0]     ax_o,
  output logic signed [W-1:0]     ay_o,
  output logic signed [2*W+2:0]   denom_o,
  output logic signed [2*W+2:0]   tnum_o,
  output logic signed [2*W+2:0]   snum_o
);
  import ssi_pkg::*;

  localparam int DW  = W + 1;
  localparam int PRW = 2 * W + 2;
  localparam int CW  = 2 * W + 3;

  logic                  v1_q, v2_q, v3_q;
  logic signed [DW-1:0]  d0x1_q, d0y1_q, d1x1_q, d1y1_q, rx1_q, ry1_q;
  logic signed [DW-1:0]  d0x2_q, d0y2_q, d0x3_q, d0y3_q;
  logic signed [W-1:0]   ax1_q, ay1_q, ax2_q, ay2_q, ax3_q, ay3_q;
  logic signed [PRW-1:0] pd0_q, pd1_q, pt0_q, pt1_q, ps0_q, ps1_q;
  logic signed [CW-1:0]  denom_q, tnum_q, snum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d0x1_q  <= DW'(a_end_x_i) - DW'(a_start_x_i);
    d0y1_q  <= DW'(a_end_y_i) - DW'(a_start_y_i);
    d1x1_q  <= DW'(b_end_x_i) - DW'(b_start_x_i);
    d1y1_q  <= DW'(b_end_y_i) - DW'(b_start_y_i);
    rx1_q   <= DW'(a_start_x_i) - DW'(b_start_x_i);
    ry1_q   <= DW'(a_start_y_i) - DW'(b_start_y_i);
    ax1_q   <= a_start_x_i;
    ay1_q   <= a_start_y_i;

    pd0_q   <= PRW'(d0x1_q) * PRW'(d1y1_q);
    pd1_q   <= PRW'(d0y1_q) * PRW'(d1x1_q);
    pt0_q   <= PRW'(d0x1_q) * PRW'(ry1_q);
    pt1_q   <= PRW'(d0y1_q) * PRW'(rx1_q);
    ps0_q   <= PRW'(d1x1_q) * PRW'(ry1_q);
    ps1_q   <= PRW'(d1y1_q) * PRW'(rx1_q);
    d0x2_q  <= d0x1_q;
    d0y2_q  <= d0y1_q;
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;

    denom_q <= CW'(pd0_q) - CW'(pd1_q);
    tnum_q  <= CW'(pt0_q) - CW'(pt1_q);
    snum_q  <= CW'(ps0_q) - CW'(ps1_q);
    d0x3_q  <= d0x2_q;
    d0y3_q  <= d0y2_q;
    ax3_q   <= ax2_q;
    ay3_q   <= ay2_q;
  end

  assign valid_o = v3_q;
  assign d0x_o   = d0x3_q;
  assign d0y_o   = d0y3_q;
  assign ax_o    = ax3_q;
  assign ay_o    = ay3_q;
  assign denom_o = denom_q;
  assign tnum_o  = tnum_q;
  assign snum_o  = snum_q;

endmodule

// ----- sv/ssi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, x and y lanes.
module ssi_div #(
  parameter int W = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ssi_pkg::ssi_ctl_t     ctl_i,
  input  logic signed [W-1:0]   ax_i,
  input  logic signed [W-1:0]   ay_i,
  input  logic [3*W+3:0]        num_x_i,
  input  logic [3*W+3:0]        num_y_i,
  input  logic [2*W+2:0]        den_i,
  output ssi_pkg::ssi_ctl_t     ctl_o,
  output logic signed [W-1:0]   ax_o,
  output logic signed [W-1:0]   ay_o,
  output logic [W:0]            quo_x_o,
  output logic [W:0]            quo_y_o
);
  import ssi_pkg::*;

  localparam int Q  = W + 1;
  localparam int CW = 2 * W + 3;
  localparam int PW = 3 * W + 4;

  ssi_ctl_t              ctl_s  [Q+1];
  logic signed [W-1:0]   ax_s   [Q+1];
  logic signed [W-1:0]   ay_s   [Q+1];
  logic [PW-1:0]         rx_s   [Q+1];
  logic [PW-1:0]         ry_s   [Q+1];
  logic [CW-1:0]         den_s  [Q+1];
  logic [Q-1:0]          qx_s   [Q+1];
  logic [Q-1:0]          qy_s   [Q+1];

  assign ctl_s[0] = ctl_i;
  assign ax_s[0]  = ax_i;
  assign ay_s[0]  = ay_i;
  assign rx_s[0]  = num_x_i;
  assign ry_s[0]  = num_y_i;
  assign den_s[0] = den_i;
  assign qx_s[0]  = '0;
  assign qy_s[0]  = '0;

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int B = Q - 1 - k;
    logic [PW-1:0] sh;
    logic          gx, gy;

    // Divisor aligned to the quotient bit this stage settles.
    assign sh = PW'(den_s[k]) << B;
    assign gx = rx_s[k] >= sh;
    assign gy = ry_s[k] >= sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_s[k+1] <= '0;
      end else begin
        ctl_s[k+1] <= ctl_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      ax_s[k+1]  <= ax_s[k];
      ay_s[k+1]  <= ay_s[k];
      den_s[k+1] <= den_s[k];
      rx_s[k+1]  <= gx ? rx_s[k] - sh : rx_s[k];
      ry_s[k+1]  <= gy ? ry_s[k] - sh : ry_s[k];
      qx_s[k+1]  <= qx_s[k] | (Q'(gx) << B);
      qy_s[k+1]  <= qy_s[k] | (Q'(gy) << B);
    end
  end

  assign ctl_o   = ctl_s[Q];
  assign ax_o    = ax_s[Q];
  assign ay_o    = ay_s[Q];
  assign quo_x_o = qx_s[Q];
  assign quo_y_o = qy_s[Q];

endmodule

// ----- sv/segment_segment_intersection_top.sv -----
// Segment-segment intersection: hit test and truncated intersection point.
// Throughput: one segment pair per cycle; busy stays low, results never stall.
// Most of the depth is in the divider, which settles one quotient bit per stage.
// Reset clears all valid bits; payload registers are not reset.
module segment_segment_intersection_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] a_start_x_i,
  input  logic signed [COORD_BITS-1:0] a_start_y_i,
  input  logic signed [COORD_BITS-1:0] a_end_x_i,
  input  logic signed [COORD_BITS-1:0] a_end_y_i,
  input  logic signed [COORD_BITS-1:0] b_start_x_i,
  input  logic signed [COORD_BITS-1:0] b_start_y_i,
  input  logic signed [COORD_BITS-1:0] b_end_x_i,
  input  logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                         done_o,
  output logic                         hit_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o
);
  import ssi_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;
  localparam int CW = 2 * W + 3;
  localparam int PW = 3 * W + 4;
  localparam int Q  = W + 1;
  localparam int RW = W + 2;

  function automatic logic in_unit(logic signed [CW-1:0] num, logic signed [CW-1:0] den);
    logic r;
    if (den[CW-1]) begin
      r = (num <= 0) && (num >= den);
    end else begin
      r = (num >= 0) && (num <= den);
    end
    return r;
  endfunction

  logic                  f_valid;
  logic signed [DW-1:0]  f_d0x, f_d0y;
  logic signed [W-1:0]   f_ax, f_ay;
  logic signed [CW-1:0]  f_denom, f_tnum, f_snum;

  ssi_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (start && !busy),
    .a_start_x_i (a_start_x_i),
    .a_start_y_i (a_start_y_i),
    .a_end_x_i   (a_end_x_i),
    .a_end_y_i   (a_end_y_i),
    .b_start_x_i (b_start_x_i),
    .b_start_y_i (b_start_y_i),
    .b_end_x_i   (b_end_x_i),
    .b_end_y_i   (b_end_y_i),
    .valid_o     (f_valid),
    .d0x_o       (f_d0x),
    .d0y_o       (f_d0y),
    .ax_o        (f_ax),
    .ay_o        (f_ay),
    .denom_o     (f_denom),
    .tnum_o      (f_tnum),
    .snum_o      (f_snum)
  );

  // Hit test and scaled numerators.
  logic                 v4_q, hit4_q;
  logic signed [PW-1:0] px4_q, py4_q;
  logic signed [CW-1:0] den4_q;
  logic signed [W-1:0]  ax4_q, ay4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= f_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit4_q <= (f_denom != '0) && in_unit(f_tnum, f_denom) && in_unit(f_snum, f_denom);
    px4_q  <= PW'(f_d0x) * PW'(f_snum);
    py4_q  <= PW'(f_d0y) * PW'(f_snum);
    den4_q <= f_denom;
    ax4_q  <= f_ax;
    ay4_q  <= f_ay;
  end

  // Take magnitudes and quotient signs.
  ssi_ctl_t             ctl5_q;
  logic [PW-1:0]        nx5_q, ny5_q;
  logic [CW-1:0]        den5_q;
  logic signed [W-1:0]  ax5_q, ay5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl5_q <= '0;
    end else begin
      ctl5_q.valid <= v4_q;
      ctl5_q.hit   <= hit4_q;
      ctl5_q.neg_x <= px4_q[PW-1] ^ den4_q[CW-1];
      ctl5_q.neg_y <= py4_q[PW-1] ^ den4_q[CW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    nx5_q  <= px4_q[PW-1] ? PW'(-px4_q) : PW'(px4_q);
    ny5_q  <= py4_q[PW-1] ? PW'(-py4_q) : PW'(py4_q);
    den5_q <= den4_q[CW-1] ? CW'(-den4_q) : CW'(den4_q);
    ax5_q  <= ax4_q;
    ay5_q  <= ay4_q;
  end

  ssi_ctl_t             dv_ctl;
  logic signed [W-1:0]  dv_ax, dv_ay;
  logic [Q-1:0]         dv_qx, dv_qy;

  ssi_div #(.W(W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl5_q),
    .ax_i    (ax5_q),
    .ay_i    (ay5_q),
    .num_x_i (nx5_q),
    .num_y_i (ny5_q),
    .den_i   (den5_q),
    .ctl_o   (dv_ctl),
    .ax_o    (dv_ax),
    .ay_o    (dv_ay),
    .quo_x_o (dv_qx),
    .quo_y_o (dv_qy)
  );

  // Apply sign, offset from A start, drop the point on a miss.
  logic signed [RW-1:0] ox, oy;
  assign ox = RW'(dv_ax) + (dv_ctl.neg_x ? -RW'(dv_qx) : RW'(dv_qx));
  assign oy = RW'(dv_ay) + (dv_ctl.neg_y ? -RW'(dv_qy) : RW'(dv_qy));

  logic                done_q, hit_q;
  logic signed [W-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv_ctl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= dv_ctl.hit;
    px_q  <= dv_ctl.hit ? ox[W-1:0] : '0;
    py_q  <= dv_ctl.hit ? oy[W-1:0] : '0;
  end

  assign busy      = 1'b0;
  assign done_o    = done_q;
  assign hit_o     = hit_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule
